FILE: rtl/ldatt_pkg.sv
// Shared types, constants and the root step function for the light distance attenuation block.
`default_nettype none
package ldatt_pkg;

  localparam int unsigned SqW   = 50;  // radicand and root working width
  localparam int unsigned DvsW  = 49;  // divisor width
  localparam int unsigned RemW  = 50;  // partial remainder width
  localparam int unsigned LowW  = 34;  // dividend bits still to shift in
  localparam int unsigned QuoW  = 34;  // quotient width

  localparam int unsigned SqrtCells = 25;  // one root bit per cell
  localparam int unsigned Div1Cells = 34;  // normalized distance quotient bits
  localparam int unsigned Div2Cells = 17;  // attenuation quotient bits

  // Configuration register indexes
  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegDecay  = 3'd1;
  localparam logic [2:0] RegSoft   = 3'd2;
  localparam logic [2:0] RegWidth  = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;

  // Falloff modes
  localparam logic [1:0] ModeNone   = 2'd0;
  localparam logic [1:0] ModeLinear = 2'd1;
  localparam logic [1:0] ModeQuadSq = 2'd2;

  localparam logic [15:0] DefWidth  = 16'd1200;
  localparam logic [15:0] DefHeight = 16'd800;
  localparam logic [15:0] MinSoft   = 16'd26;
  localparam logic [16:0] AttOne    = 17'd65536;

  typedef struct packed {
    logic [SqW-1:0] v;
    logic [SqW-1:0] r;
  } root_lane_t;

  typedef struct packed {
    root_lane_t         dlen;
    root_lane_t         diag;
    logic [4:0]         k;      // current bit pair is 4^k
    logic [1:0]         mode;
    logic signed [23:0] inten;
    logic [23:0]        decay;
    logic [15:0]        softm;
  } sqrt_t;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [LowW-1:0]    low;
    logic [QuoW-1:0]    quo;
    logic [DvsW-1:0]    dvs;
    logic [1:0]         mode;
    logic signed [23:0] inten;
    logic               far;
  } div_t;

  // One digit of the square root: try to take r + 4^k out of v.
  function automatic root_lane_t root_step(root_lane_t in, logic [4:0] k);
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] t;
    root_lane_t     o;
    bitv = SqW'(1) << {k, 1'b0};
    t    = in.r + bitv;
    if (in.v >= t) begin
      o.v = in.v - t;
      o.r = (in.r >> 1) + bitv;
    end else begin
      o.v = in.v;
      o.r = in.r >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ldatt_sqrt_cell.sv
// Square root cell: one root bit for the distance and the window diagonal lanes.
`default_nettype none
module ldatt_sqrt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire ldatt_pkg::sqrt_t data_i,
  output logic                valid_o,
  output ldatt_pkg::sqrt_t    data_o
);

  logic             valid_q;
  ldatt_pkg::sqrt_t data_d, data_q;

  always_comb begin
    data_d      = data_i;
    data_d.dlen = ldatt_pkg::root_step(data_i.dlen, data_i.k);
    data_d.diag = ldatt_pkg::root_step(data_i.diag, data_i.k);
    data_d.k    = data_i.k - 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

FILE: rtl/ldatt_div_cell.sv
// Restoring divider cell: one quotient bit per cycle.
`default_nettype none
module ldatt_div_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire ldatt_pkg::div_t data_i,
  output logic                 valid_o,
  output ldatt_pkg::div_t      data_o
);

  logic                          valid_q;
  ldatt_pkg::div_t               data_d, data_q;
  logic [ldatt_pkg::RemW-1:0]    shifted;

  always_comb begin
    data_d  = data_i;
    shifted = {data_i.rem[ldatt_pkg::RemW-2:0], data_i.low[ldatt_pkg::LowW-1]};
    data_d.low = {data_i.low[ldatt_pkg::LowW-2:0], 1'b0};
    if (shifted >= ldatt_pkg::RemW'(data_i.dvs)) begin
      data_d.rem = shifted - ldatt_pkg::RemW'(data_i.dvs);
      data_d.quo = {data_i.quo[ldatt_pkg::QuoW-2:0], 1'b1};
    end else begin
      data_d.rem = shifted;
      data_d.quo = {data_i.quo[ldatt_pkg::QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

FILE: rtl/light_distance_attenuation_top.sv
// Top level of the point light distance falloff pipeline.
// The block takes one word per cycle and never raises busy; each word gives one
// radiance word on result_valid_o. Its path runs through the cell rows: 25 square
// root cells, 34 cells for the normalized distance quotient and 17 cells for the
// attenuation quotient, plus input, multiply and output stages. The receiver cannot
// stall the result. Registers are sampled when a word is taken and must not change
// while words are in flight.
`default_nettype none
module light_distance_attenuation_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [23:0] light_x_i,
  input  wire logic signed [23:0] light_y_i,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic signed [23:0] intensity_i,
  output logic                    result_valid_o,
  output logic [23:0]             radiance_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);

  // Configuration registers
  logic [1:0]  mode_q;
  logic [23:0] decay_q;
  logic [15:0] soft_q;
  logic [15:0] width_q;
  logic [15:0] height_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ldatt_pkg::ModeNone;
      decay_q  <= 24'd0;
      soft_q   <= 16'd256;
      width_q  <= ldatt_pkg::DefWidth;
      height_q <= ldatt_pkg::DefHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ldatt_pkg::RegMode:   mode_q   <= cfg_data_i[1:0];
        ldatt_pkg::RegDecay:  decay_q  <= cfg_data_i;
        ldatt_pkg::RegSoft:   soft_q   <= cfg_data_i[15:0];
        ldatt_pkg::RegWidth:  width_q  <= cfg_data_i[15:0];
        ldatt_pkg::RegHeight: height_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Stage 0: differences, magnitudes and register defaults
  logic signed [24:0] dx, dy;
  logic [24:0]        adx_d, ady_d;
  logic               s0_vld_q;
  logic [24:0]        adx_q, ady_q;
  logic [15:0]        w_q, h_q;
  logic [1:0]         s0_mode_q;
  logic signed [23:0] s0_inten_q;
  logic [23:0]        s0_decay_q;
  logic [15:0]        s0_soft_q;

  assign dx    = {light_x_i[23], light_x_i} - {point_x_i[23], point_x_i};
  assign dy    = {light_y_i[23], light_y_i} - {point_y_i[23], point_y_i};
  assign adx_d = dx[24] ? 25'(-dx) : 25'(dx);
  assign ady_d = dy[24] ? 25'(-dy) : 25'(dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    w_q        <= (width_q == 16'd0) ? ldatt_pkg::DefWidth : width_q;
    h_q        <= (height_q == 16'd0) ? ldatt_pkg::DefHeight : height_q;
    s0_mode_q  <= mode_q;
    s0_inten_q <= intensity_i;
    s0_decay_q <= decay_q;
    s0_soft_q  <= (soft_q < ldatt_pkg::MinSoft) ? ldatt_pkg::MinSoft : soft_q;
  end

  // Stage 1: squares feed the root row
  ldatt_pkg::sqrt_t sq_d;
  ldatt_pkg::sqrt_t sq_data [0:ldatt_pkg::SqrtCells];
  logic             sq_vld  [0:ldatt_pkg::SqrtCells];
  logic [49:0]      dsq;
  logic [33:0]      wsq;

  assign dsq = (50'(adx_q) * 50'(adx_q)) + (50'(ady_q) * 50'(ady_q));
  assign wsq = (34'(w_q) * 34'(w_q)) + (34'(h_q) * 34'(h_q));

  always_comb begin
    sq_d.dlen.v = dsq;
    sq_d.dlen.r = '0;
    sq_d.diag.v = {wsq, 16'd0};
    sq_d.diag.r = '0;
    sq_d.k      = 5'(ldatt_pkg::SqrtCells - 1);
    sq_d.mode   = s0_mode_q;
    sq_d.inten  = s0_inten_q;
    sq_d.decay  = s0_decay_q;
    sq_d.softm  = s0_soft_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_data[0] <= sq_d;
  end

  for (genvar i = 0; i < ldatt_pkg::SqrtCells; i++) begin : g_sqrt
    ldatt_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_vld[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // Scale and first divider setup: n = (dist << 24) / scale
  ldatt_pkg::sqrt_t  sq_end;
  logic [24:0]       dist_len, fall;
  logic [40:0]       scale_raw;
  ldatt_pkg::div_t   d1_d;
  ldatt_pkg::div_t   d1_data [0:ldatt_pkg::Div1Cells];
  logic              d1_vld  [0:ldatt_pkg::Div1Cells];

  assign sq_end    = sq_data[ldatt_pkg::SqrtCells];
  assign dist_len  = sq_end.dlen.r[24:0];
  assign fall      = (sq_end.decay != 24'd0) ? {1'b0, sq_end.decay} : sq_end.diag.r[24:0];
  assign scale_raw = 41'(fall) * 41'(sq_end.softm);

  always_comb begin
    d1_d.rem   = ldatt_pkg::RemW'(dist_len[24:10]);
    d1_d.low   = {dist_len[9:0], 24'd0};
    d1_d.quo   = '0;
    d1_d.dvs   = (scale_raw < 41'd65536) ? ldatt_pkg::DvsW'(65536)
                                          : ldatt_pkg::DvsW'(scale_raw);
    d1_d.mode  = sq_end.mode;
    d1_d.inten = sq_end.inten;
    d1_d.far   = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld[0] <= 1'b0;
    end else begin
      d1_vld[0] <= sq_vld[ldatt_pkg::SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    d1_data[0] <= d1_d;
  end

  for (genvar i = 0; i < ldatt_pkg::Div1Cells; i++) begin : g_div1
    ldatt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d1_vld[i]),
      .data_i  (d1_data[i]),
      .valid_o (d1_vld[i+1]),
      .data_o  (d1_data[i+1])
    );
  end

  // Second divider setup: linear 2^32/(2^16+n), quadratic 2^48/(2^32+n^2)
  ldatt_pkg::div_t   d1_end;
  logic [33:0]       n_val;
  logic [47:0]       nsq;
  ldatt_pkg::div_t   d2_d;
  ldatt_pkg::div_t   d2_data [0:ldatt_pkg::Div2Cells];
  logic              d2_vld  [0:ldatt_pkg::Div2Cells];

  assign d1_end = d1_data[ldatt_pkg::Div1Cells];
  assign n_val  = d1_end.quo;
  assign nsq    = n_val[23:0] * n_val[23:0];

  always_comb begin
    d2_d       = d1_end;
    d2_d.low   = '0;
    d2_d.quo   = '0;
    d2_d.far   = (n_val[33:24] != 10'd0);
    if (d1_end.mode == ldatt_pkg::ModeLinear) begin
      d2_d.rem = ldatt_pkg::RemW'(1) << 15;
      d2_d.dvs = ldatt_pkg::DvsW'(n_val) + ldatt_pkg::DvsW'(65536);
    end else begin
      d2_d.rem = ldatt_pkg::RemW'(1) << 31;
      d2_d.dvs = ldatt_pkg::DvsW'(nsq) + (ldatt_pkg::DvsW'(1) << 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_vld[0] <= 1'b0;
    end else begin
      d2_vld[0] <= d1_vld[ldatt_pkg::Div1Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    d2_data[0] <= d2_d;
  end

  for (genvar i = 0; i < ldatt_pkg::Div2Cells; i++) begin : g_div2
    ldatt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d2_vld[i]),
      .data_i  (d2_data[i]),
      .valid_o (d2_vld[i+1]),
      .data_o  (d2_data[i+1])
    );
  end

  // Attenuation select, extra squaring, intensity scaling
  ldatt_pkg::div_t    d2_end;
  logic [16:0]        att_d;
  logic               a_vld_q, b_vld_q, out_vld_q;
  logic [16:0]        att_a_q, att_b_q;
  logic [1:0]         a_mode_q;
  logic signed [23:0] a_inten_q, b_inten_q;
  logic [33:0]        att_sq;
  logic [39:0]        rad_prod;
  logic [23:0]        rad_d, rad_q;

  assign d2_end = d2_data[ldatt_pkg::Div2Cells];

  always_comb begin
    priority if (d2_end.mode == ldatt_pkg::ModeNone) begin
      att_d = ldatt_pkg::AttOne;
    end else if (d2_end.mode == ldatt_pkg::ModeLinear) begin
      att_d = d2_end.quo[16:0];
    end else if (d2_end.far) begin
      att_d = 17'd0;
    end else begin
      att_d = d2_end.quo[16:0];
    end
  end

  assign att_sq   = 34'(att_a_q) * 34'(att_a_q);
  assign rad_prod = 40'(b_inten_q[22:0]) * 40'(att_b_q);

  always_comb begin
    if (b_inten_q[23] || (b_inten_q == 24'sd0)) begin
      rad_d = 24'd0;
    end else if (rad_prod[39:16] > 24'hFFFFFF) begin
      rad_d = 24'hFFFFFF;
    end else begin
      rad_d = rad_prod[39:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      a_vld_q   <= d2_vld[ldatt_pkg::Div2Cells];
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    att_a_q   <= att_d;
    a_mode_q  <= d2_end.mode;
    a_inten_q <= d2_end.inten;
    att_b_q   <= (a_mode_q == ldatt_pkg::ModeQuadSq) ? att_sq[32:16] : att_a_q;
    b_inten_q <= a_inten_q;
    rad_q     <= rad_d;
  end

  assign result_valid_o = out_vld_q;
  assign radiance_o     = rad_q;

endmodule
`default_nettype wire

FILE: sim/light_distance_attenuation_chk.sv
// Checker for the light distance attenuation block: predicts and compares radiance words.
`timescale 1ns / 100ps
module light_distance_attenuation_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] light_x_i,
  input  logic signed [23:0] light_y_i,
  input  logic signed [23:0] point_x_i,
  input  logic signed [23:0] point_y_i,
  input  logic signed [23:0] intensity_i,
  input  logic               result_valid_o,
  input  logic [23:0]        radiance_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);

  logic [1:0]  mode_q;
  logic [23:0] decay_q;
  logic [15:0] soft_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [23:0] radiance_due[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] attenuated_radiance(
      logic signed [23:0] lx, logic signed [23:0] ly,
      logic signed [23:0] px, logic signed [23:0] py, logic signed [23:0] inten);
    longint      dx;
    longint      dy;
    logic [63:0] dist_len;
    logic [63:0] fall;
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] sf;
    logic [63:0] scale;
    logic [63:0] n;
    logic [63:0] att;
    logic [63:0] rad;
    dx = longint'(lx) - longint'(px);
    dy = longint'(ly) - longint'(py);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    dist_len = int_sqrt(64'(dx * dx + dy * dy));
    if (decay_q != 0) begin
      fall = 64'(decay_q);
    end else begin
      w = (width_q != 0) ? 64'(width_q) : 64'(ldatt_pkg::DefWidth);
      h = (height_q != 0) ? 64'(height_q) : 64'(ldatt_pkg::DefHeight);
      fall = int_sqrt((w * w + h * h) << 16);
    end
    sf = (soft_q < ldatt_pkg::MinSoft) ? 64'(ldatt_pkg::MinSoft) : 64'(soft_q);
    scale = fall * sf;
    if (scale < 64'd65536) scale = 64'd65536;
    n = (dist_len << 24) / scale;
    if (mode_q == ldatt_pkg::ModeNone) begin
      att = 64'd65536;
    end else if (mode_q == ldatt_pkg::ModeLinear) begin
      att = (64'd1 << 32) / (64'd65536 + n);
    end else begin
      // far point: quadratic attenuation drops to zero
      att = (n >= (64'd1 << 24)) ? 64'd0 : (64'd1 << 48) / ((64'd1 << 32) + n * n);
      if (mode_q == ldatt_pkg::ModeQuadSq) att = (att * att) >> 16;
    end
    if (inten <= 0) return 24'd0;
    rad = (64'(inten) * att) >> 16;
    return (rad > 64'hFFFFFF) ? 24'hFFFFFF : rad[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ldatt_pkg::ModeNone;
      decay_q  <= '0;
      soft_q   <= 16'd256;
      width_q  <= ldatt_pkg::DefWidth;
      height_q <= ldatt_pkg::DefHeight;
      errors_o <= 0;
      results_o <= 0;
      radiance_due.delete();
    end else begin
      if (start && !busy)
        radiance_due.push_back(attenuated_radiance(light_x_i, light_y_i, point_x_i,
                                                   point_y_i, intensity_i));
      if (result_valid_o) begin
        results_o <= results_o + 1;
        if (radiance_due.size() == 0) begin
          if (errors_o < 10) $display("ERROR: radiance word %0h with none expected",
                                      radiance_o);
          errors_o <= errors_o + 1;
        end else begin
          if (radiance_o !== radiance_due[0]) begin
            if (errors_o < 10) $display("ERROR: radiance expected %0h got %0h",
                                        radiance_due[0], radiance_o);
            errors_o <= errors_o + 1;
          end
          void'(radiance_due.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ldatt_pkg::RegMode:   mode_q   <= cfg_data_i[1:0];
          ldatt_pkg::RegDecay:  decay_q  <= cfg_data_i;
          ldatt_pkg::RegSoft:   soft_q   <= cfg_data_i[15:0];
          ldatt_pkg::RegWidth:  width_q  <= cfg_data_i[15:0];
          ldatt_pkg::RegHeight: height_q <= cfg_data_i[15:0];
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  assign pending_o = radiance_due.size();

endmodule

FILE: sim/light_distance_attenuation_top_tb.sv
// Testbench top: drives items and register writes, gives the verdict.
`timescale 1ns / 100ps
module light_distance_attenuation_top_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] light_x_i = '0;
  logic signed [23:0] light_y_i = '0;
  logic signed [23:0] point_x_i = '0;
  logic signed [23:0] point_y_i = '0;
  logic signed [23:0] intensity_i = '0;
  logic               result_valid_o;
  logic [23:0]        radiance_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  int                 errors;
  int                 pending;
  int                 results;
  int                 words_sent;

  always #5 clk_i = ~clk_i;

  light_distance_attenuation_top u_dut (.*);

  light_distance_attenuation_chk u_chk (
    .*, .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_word(logic [23:0] lx, logic [23:0] ly, logic [23:0] px,
                           logic [23:0] py, logic [23:0] inten);
    start       <= 1'b1;
    light_x_i   <= lx;
    light_y_i   <= ly;
    point_x_i   <= px;
    point_y_i   <= py;
    intensity_i <= inten;
    do @(posedge clk_i); while (busy);
    words_sent++;
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_pos(int k);
    return 24'($urandom_range(0, 2 * (1 << k)) - (1 << k));
  endfunction

  task automatic random_words(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(6, 20);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
      send_word(rand_pos(k), rand_pos(k), rand_pos(k), rand_pos(k), 24'($urandom));
    end
  endtask

  task automatic directed_words();
    send_word(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
    send_word(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_word('0, '0, '0, '0, 24'h7FFFFF);
    send_word('0, '0, '0, '0, 24'h800000);
    send_word('0, '0, '0, '0, 24'h000000);
    send_word('0, '0, '0, '0, 24'h000001);
    send_word(24'h000100, '0, '0, 24'h000100, 24'h010000);
    send_word(24'h7FFFFF, '0, 24'h800000, '0, 24'h400000);
  endtask

  initial begin
    logic [23:0] decays[4];
    logic [15:0] softs[4];
    logic [15:0] dims[3];
    decays = '{24'd0, 24'hFFFFFF, 24'd1, 24'd25600};
    softs  = '{16'd0, 16'd26, 16'hFFFF, 16'd256};
    dims   = '{16'd0, 16'hFFFF, 16'd640};
    words_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ldatt_pkg::RegMode, 24'(ph % 4));  // includes the undocumented mode three
      write_reg(ldatt_pkg::RegDecay, (ph == 7) ? 24'($urandom) : decays[ph % 4]);
      write_reg(ldatt_pkg::RegSoft,
                24'((ph == 6) ? 16'($urandom) : softs[(ph + 1) % 4]));
      write_reg(ldatt_pkg::RegWidth, 24'(dims[ph % 3]));
      write_reg(ldatt_pkg::RegHeight, 24'(dims[(ph + 2) % 3]));
      write_reg(3'd5 + 3'(ph % 3), 24'($urandom));  // ignored index
      if (ph == 0) directed_words();
      random_words(48);
      drain();
    end
    $display("Sent %0d words over 9 register settings, checked %0d radiance words.",
             words_sent, results);
    $display("Modes 0..3, decay and window extremes, softness clamp and sign cases hit.");
    if (errors == 0) begin
      $display("light_distance_attenuation_top test passed");
    end else begin
      $display("light_distance_attenuation_top test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TIMEOUT");
    $display("light_distance_attenuation_top test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ldatt_pkg.sv
rtl/ldatt_sqrt_cell.sv
rtl/ldatt_div_cell.sv
rtl/light_distance_attenuation_top.sv
sim/light_distance_attenuation_chk.sv
sim/light_distance_attenuation_top_tb.sv
